[design/lsb_first_bit_field_reader_assert.svh]
// ----------------------------------------------------------------------------
// lsb_first_bit_field_reader assertion macros
// Short forms for the concurrent checks of the bit field reader. They expect
// clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_FIELD_READER_ASSERT_SVH
`define LSB_FIRST_BIT_FIELD_READER_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define LSBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is held.
`define LSBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lsbr_pkg.sv]
// ----------------------------------------------------------------------------
// lsbr_pkg
// Shared types and constants of the LSB-first bit field reader.
// ----------------------------------------------------------------------------
package lsbr_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BYTE_SHIFT    = 3;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned MAX_READ_BITS = 64;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned START_W       = 11;
  localparam int unsigned TOTAL_W       = 12;
  // start offset plus consumed bits: up to 2047 + 4095
  localparam int unsigned POS_W         = 13;
  localparam int unsigned IN_DATA_W     = 24;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned CMDQ_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS   = 2'd1;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'b001,
    CMD_READ   = 3'b010,
    CMD_REJECT = 3'b100
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [POS_W-1:0]          base;
    logic [COUNT_W-1:0]        count;
    logic [BYTE_W-1:0]         addr;
    logic [BYTE_W-1:0]         data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_status_t;

endpackage

[design/lsbr_ram.sv]
// ----------------------------------------------------------------------------
// lsbr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/lsbr_front.sv]
// ----------------------------------------------------------------------------
// lsbr_front
// Accepts input items, checks reads against the window and buffer, tracks the
// consumed bit count and hands classified commands to the command queue.
// ----------------------------------------------------------------------------
module lsbr_front import lsbr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmdq_status_t          q_status,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  localparam int unsigned BUF_BITS = BUFFER_BYTES * BITS_PER_BYTE;
  localparam int unsigned BB_W     = $clog2(BUF_BITS + 1);
  localparam int unsigned CMP_W    = (BB_W > POS_W) ? BB_W : POS_W;

  logic [START_W-1:0] start_r, start_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] consumed_r, consumed_nxt;

  logic               action;
  logic [BYTE_W-1:0]  addr;
  logic [BYTE_W-1:0]  data;
  logic [COUNT_W-1:0] count;
  logic [TOTAL_W-1:0] remaining;
  logic [POS_W-1:0]   base;
  logic [CMP_W-1:0]   base_w;
  logic [CMP_W-1:0]   room;
  logic               past_end;
  logic               bad;
  logic               load_ok;
  logic               accept;
  logic               cfg_wr;

  assign action = in_tuser;
  assign addr   = in_tdata[BYTE_W-1:0];
  assign data   = in_tdata[2*BYTE_W-1:BYTE_W];
  assign count  = in_tdata[2*BYTE_W+COUNT_W-1:2*BYTE_W];

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    remaining = (total_r > consumed_r) ? (total_r - consumed_r) : '0;
    base      = POS_W'(start_r) + POS_W'(consumed_r);
    base_w    = CMP_W'(base);
    past_end  = base_w > CMP_W'(BUF_BITS);
    room      = CMP_W'(BUF_BITS) - base_w;
    bad       = (count == '0) || (count > COUNT_W'(MAX_READ_BITS))
             || (TOTAL_W'(count) > remaining) || past_end
             || (CMP_W'(count) > room);
    load_ok   = 32'(addr) < 32'(BUFFER_BYTES);
  end

  always_comb begin
    q_cmd.base  = base;
    q_cmd.count = count;
    q_cmd.addr  = addr;
    q_cmd.data  = data;
    if (action == ACTION_READ) begin
      q_cmd.kind = bad ? CMD_REJECT : CMD_READ;
    end else begin
      q_cmd.kind = CMD_LOAD;
    end
    // drop loads that fall outside the buffer
    q_push = accept && ((action == ACTION_READ) || load_ok);
  end

  always_comb begin
    start_nxt    = start_r;
    total_nxt    = total_r;
    consumed_nxt = consumed_r;
    priority if (cfg_wr && (cfg_index == CFG_START_OFFSET)) begin
      start_nxt    = cfg_data[START_W-1:0];
      consumed_nxt = '0;
    end else if (cfg_wr && (cfg_index == CFG_TOTAL_BITS)) begin
      total_nxt    = cfg_data[TOTAL_W-1:0];
      consumed_nxt = '0;
    end else if (accept && (action == ACTION_READ) && !bad) begin
      consumed_nxt = consumed_r + TOTAL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      total_r    <= '0;
      consumed_r <= '0;
    end else begin
      start_r    <= start_nxt;
      total_r    <= total_nxt;
      consumed_r <= consumed_nxt;
    end
  end

endmodule

[design/lsbr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lsbr_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lsbr_cmd_fifo import lsbr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head_cmd,
  output cmdq_status_t status
);

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[design/lsbr_back.sv]
// ----------------------------------------------------------------------------
// lsbr_back
// Executes queued commands: writes loads into the buffer RAM, streams reads out
// one merged byte per cycle unless the output stalls, held in an output register.
// ----------------------------------------------------------------------------
`include "lsb_first_bit_field_reader_assert.svh"

module lsbr_back import lsbr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned AW           = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmdq_status_t      q_status,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_PRIME = 3'b010,
    BK_EMIT  = 3'b100
  } back_state_t;

  back_state_t              state_r, state_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [BYTE_SHIFT-1:0]    sh_r, sh_nxt;
  logic [COUNT_W-1:0]       rem_r, rem_nxt;
  logic [BYTE_W-1:0]        prev_r, prev_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]        out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_err_r, out_err_nxt;

  logic                     slot_free;
  logic                     load_out;
  logic [2*BYTE_W-1:0]      merged;
  logic [BYTE_W-1:0]        mask;
  logic                     is_last;
  logic [AW-1:0]            head_addr;

  assign slot_free = !out_valid_r || out_tready;
  assign head_addr = AW'(q_cmd.base[POS_W-1:BYTE_SHIFT]);
  assign merged    = {ram_rdata, prev_r} >> sh_r;
  assign is_last   = rem_r <= COUNT_W'(BITS_PER_BYTE);
  assign mask      = (rem_r >= COUNT_W'(BITS_PER_BYTE)) ? '1 : ~('1 << rem_r[BYTE_SHIFT-1:0]);

  assign ram_waddr = AW'(q_cmd.addr);
  assign ram_wdata = q_cmd.data;

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    sh_nxt       = sh_r;
    rem_nxt      = rem_r;
    prev_nxt     = prev_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = addr_r + 1'b1;
    load_out     = 1'b0;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
            end
            CMD_READ: begin
              q_pop     = 1'b1;
              ram_re    = 1'b1;
              ram_raddr = head_addr;
              addr_nxt  = head_addr;
              sh_nxt    = q_cmd.base[BYTE_SHIFT-1:0];
              rem_nxt   = q_cmd.count;
              state_nxt = BK_PRIME;
            end
            CMD_REJECT: begin
              if (slot_free) begin
                q_pop        = 1'b1;
                load_out     = 1'b1;
                out_data_nxt = '0;
                out_last_nxt = 1'b1;
                out_err_nxt  = 1'b1;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_PRIME: begin
        // first byte is in; fetch its successor for the merge
        prev_nxt  = ram_rdata;
        ram_re    = 1'b1;
        addr_nxt  = addr_r + 1'b1;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          load_out     = 1'b1;
          out_data_nxt = merged[BYTE_W-1:0] & mask;
          out_last_nxt = is_last;
          out_err_nxt  = 1'b0;
          prev_nxt     = ram_rdata;
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            ram_re    = 1'b1;
            addr_nxt  = addr_r + 1'b1;
            rem_nxt   = rem_r - COUNT_W'(BITS_PER_BYTE);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  `LSBR_ASSERT_NOW(a_reject_single_zero, out_valid_r && out_err_r,
                   out_last_r && (out_data_r == '0), "rejected read must be one zero last byte")
  `LSBR_ASSERT_NOW(a_emit_has_bits, state_r == BK_EMIT, rem_r != '0,
                   "emitting with no bits left")
  `LSBR_ASSERT_NEXT(a_prime_to_emit, state_r == BK_PRIME, state_r == BK_EMIT,
                    "priming must lead straight to emitting")

endmodule

[design/lsb_first_bit_field_reader.sv]
// LSB-first bit field reader. Load items (tuser = 0) write one byte into the
// buffer; loads beyond the buffer are dropped. Read items (tuser = 1) return
// ceil(count/8) bytes packed LSB-first from the stream at start offset plus the
// bits consumed so far, the last byte zero-padded and flagged with tlast; a bad
// count gives one zero byte with tlast and tuser (error) set. Rate: the front
// end takes one item per cycle while the two-entry command queue has room. In
// the back end a load is written from idle, a rejected read gives its error
// byte from idle once the output register is free, and a good read passes a
// prime state on the single buffer RAM read port, then emits one byte per
// cycle unless the output stalls. Writing either configuration register clears
// the consumed bit count; write configuration only while the block is idle.
// ----------------------------------------------------------------------------
// lsb_first_bit_field_reader
// Top level: front end, command queue, back end and buffer RAM.
// ----------------------------------------------------------------------------
module lsb_first_bit_field_reader import lsbr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // load_address[7:0], load_byte[15:8],
                                            // read_count[22:16], zero pad[23]
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // out_byte[7:0]
  output logic                  out_tlast,
  output logic                  out_tuser,  // error
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  cmdq_status_t      q_status;
  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_pop;
  cmd_t              q_head_cmd;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  lsbr_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  lsbr_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .status   (q_status)
  );

  lsbr_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_cmd      (q_head_cmd),
    .q_pop      (q_pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  lsbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LSB-first bit field reader. Directed tests cover
// count and window extremes, the end of the buffer and an unused register
// index. Randomized phases then mix loads, reads and bad reads under several
// idle and stall patterns. A local model of the buffer and the bit position
// predicts every result byte.
// ----------------------------------------------------------------------------
module tb_top import lsbr_pkg::*;;

  localparam int unsigned BUF_BYTES    = 256;
  localparam int unsigned BUF_BITS     = BUF_BYTES * BITS_PER_BYTE;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } out_beat_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // local copy of the block's state
  logic [BYTE_W-1:0]  buf_mem [BUF_BYTES];
  bit                 loaded  [BUF_BYTES];
  logic [TOTAL_W-1:0] consumed  = '0;
  logic [START_W-1:0] win_start = '0;
  logic [TOTAL_W-1:0] win_total = '0;

  out_beat_t expected_bytes [$];
  int        mismatch_cnt   = 0;
  int        items_sent     = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;

  lsb_first_bit_field_reader #(.BUFFER_BYTES(BUF_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit read_fits(int unsigned cnt);
    int unsigned left;
    int unsigned base;
    left = (win_total > consumed) ? win_total - consumed : 0;
    base = win_start + consumed;
    return !(cnt == 0 || cnt > MAX_READ_BITS || cnt > left || base > BUF_BITS ||
             cnt > BUF_BITS - base);
  endfunction

  function automatic void predict_read(int unsigned cnt);
    int unsigned base;
    int unsigned nbytes;
    int unsigned pos;
    out_beat_t   beat;
    if (!read_fits(cnt)) begin
      beat.data = '0;
      beat.last = 1'b1;
      beat.err  = 1'b1;
      expected_bytes.push_back(beat);
      return;
    end
    base   = win_start + consumed;
    nbytes = (cnt + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
    for (int unsigned i = 0; i < nbytes; i++) begin
      beat.data = '0;
      for (int unsigned b = 0; b < BITS_PER_BYTE; b++) begin
        if (i * BITS_PER_BYTE + b < cnt) begin
          pos = base + i * BITS_PER_BYTE + b;
          beat.data[b] = buf_mem[pos >> BYTE_SHIFT][pos & 7];
        end
      end
      beat.last = (i + 1 == nbytes);
      beat.err  = 1'b0;
      expected_bytes.push_back(beat);
    end
    consumed = consumed + cnt[TOTAL_W-1:0];
  endfunction

  // Result side: random stall, compare each transfer with the oldest beat.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h last %0b error %0b",
                 out_tdata, out_tlast, out_tuser);
          mismatch_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_tdata);
            mismatch_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_tlast);
            mismatch_cnt++;
          end
          if (out_tuser !== want.err) begin
            $error("error: expected %0b, actual %0b", want.err, out_tuser);
            mismatch_cnt++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(logic act, int unsigned addr, int unsigned bval,
                           int unsigned cnt);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, cnt[COUNT_W-1:0], bval[BYTE_W-1:0], addr[BYTE_W-1:0]};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == ACTION_LOAD) begin
      buf_mem[addr[BYTE_W-1:0]] = bval[BYTE_W-1:0];
      loaded[addr[BYTE_W-1:0]]  = 1'b1;
    end else begin
      predict_read(cnt);
    end
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // Load any byte the read will touch that has never been written, then read.
  task automatic safe_read(int unsigned cnt);
    int unsigned first;
    int unsigned final_byte;
    if (read_fits(cnt)) begin
      first      = (win_start + consumed) >> BYTE_SHIFT;
      final_byte = (win_start + consumed + cnt - 1) >> BYTE_SHIFT;
      for (int unsigned a = first; a <= final_byte; a++)
        if (!loaded[a])
          send_item(ACTION_LOAD, a, $urandom_range(255), $urandom_range(127));
    end
    send_item(ACTION_READ, $urandom_range(255), $urandom_range(255), cnt);
  endtask

  task automatic wait_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // Loads give no result: leave time for them to retire before a write.
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_OFFSET) begin
      win_start = value[START_W-1:0];
      consumed  = '0;
    end else if (idx == CFG_TOTAL_BITS) begin
      win_total = value[TOTAL_W-1:0];
      consumed  = '0;
    end
    @(posedge clk);
  endtask

  task automatic test_empty_window();
    safe_read(8);
    safe_read(0);
  endtask

  task automatic test_count_extremes();
    settle();
    cfg_write(CFG_START_OFFSET, 0);
    cfg_write(CFG_TOTAL_BITS, BUF_BITS);
    send_item(ACTION_LOAD, 0, 8'h00, 7'h7f);
    send_item(ACTION_LOAD, BUF_BYTES - 1, 8'hff, 7'h00);
    send_item(ACTION_LOAD, 0, 8'ha5, 0);
    safe_read(1);
    safe_read(8);
    safe_read(9);
    safe_read(MAX_READ_BITS);
    safe_read(MAX_READ_BITS + 1);
    safe_read(127);
  endtask

  task automatic test_window_limits();
    settle();
    cfg_write(CFG_START_OFFSET, 13);
    cfg_write(CFG_TOTAL_BITS, 20);
    safe_read(16);
    safe_read(5);
    safe_read(4);
    safe_read(1);
  endtask

  task automatic test_buffer_end();
    settle();
    // top data bit is dropped: start lands on the last buffer bit
    cfg_write(CFG_START_OFFSET, 12'hfff);
    cfg_write(CFG_TOTAL_BITS, 12'hfff);
    safe_read(2);
    safe_read(1);
  endtask

  task automatic test_unused_index();
    settle();
    // no effect, so the position stays at the buffer end
    cfg_write(CFG_UNUSED, $urandom_range(4095));
    safe_read(1);
  endtask

  task automatic random_config();
    int unsigned start_val;
    int unsigned total_val;
    case ($urandom_range(3))
      0:       start_val = $urandom_range(4095);
      1:       start_val = 0;
      default: start_val = ($urandom_range(1) << START_W) | $urandom_range(768);
    endcase
    case ($urandom_range(3))
      0:       total_val = $urandom_range(4095);
      1:       total_val = ($urandom_range(1) == 0) ? 0 : 4095;
      default: total_val = BUF_BITS;
    endcase
    cfg_write(CFG_START_OFFSET, start_val);
    cfg_write(CFG_TOTAL_BITS, total_val);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int          stop_at;
    int          mid_at;
    bit          paused;
    int unsigned r;
    settle();
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    random_config();
    stop_at = items_sent + n_items;
    mid_at  = items_sent + n_items / 2;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (!paused && items_sent >= mid_at) begin
        wait_drained();
        paused = 1'b1;
      end else if (r < 20) begin
        send_item(ACTION_LOAD, $urandom_range(255), $urandom_range(255),
                  $urandom_range(127));
      end else if (r < 27) begin
        case ($urandom_range(2))
          0:       safe_read(0);
          1:       safe_read($urandom_range(127, MAX_READ_BITS + 1));
          default: safe_read($urandom_range(127));
        endcase
      end else if (r < 30) begin
        settle();
        random_config();
      end else if (r < 60) begin
        safe_read($urandom_range(BITS_PER_BYTE, 1));
      end else begin
        safe_read($urandom_range(MAX_READ_BITS, 1));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_window();
    test_count_extremes();
    test_window_limits();
    test_buffer_end();
    test_unused_index();
    test_random_traffic(0, 0, 20);
    test_random_traffic(48, 0, 20);
    test_random_traffic(0, 48, 20);
    test_random_traffic(29, 29, 20);
    settle();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
